// File: hdl/ycq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycq_pkg
// Types and coefficients shared by the 4:2:0 quad to RGB converter.
// ----------------------------------------------------------------------------
package ycq_pkg;

	localparam int unsigned SampleW = 8;
	localparam int unsigned ProdW   = 18;
	localparam int unsigned SumW    = 11;
	localparam int unsigned Pixels  = 4;

	// bt.601 limited range, scaled by 256
	localparam logic signed [ProdW-1:0] CoefY     = 18'sd298;
	localparam logic signed [ProdW-1:0] CoefCrRed = 18'sd409;
	localparam logic signed [ProdW-1:0] CoefCbBlu = 18'sd516;
	localparam logic signed [ProdW-1:0] CoefCrGrn = 18'sd208;
	localparam logic signed [ProdW-1:0] CoefCbGrn = 18'sd100;
	localparam logic signed [ProdW-1:0] LumaOfs   = 18'sd16;
	localparam logic signed [ProdW-1:0] ChromaOfs = 18'sd128;
	localparam logic signed [ProdW-1:0] RoundHalf = 18'sd128;

	typedef struct packed {
		logic [Pixels-1:0][SampleW-1:0] luma;   // tl, tr, bl, br
		logic [SampleW-1:0]             chroma_blue;
		logic [SampleW-1:0]             chroma_red;
	} ycq_quad_t;

	typedef struct packed {
		logic [Pixels-1:0][ProdW-1:0] y_prod;
		logic [16:0]                  red_prod;
		logic [17:0]                  blue_prod;
		logic [15:0]                  grn_cr_prod;
		logic [14:0]                  grn_cb_prod;
	} ycq_prod_t;

	typedef struct packed {
		logic [Pixels-1:0][SumW-1:0] red;
		logic [Pixels-1:0][SumW-1:0] green;
		logic [Pixels-1:0][SumW-1:0] blue;
	} ycq_sum_t;

	typedef struct packed {
		logic [Pixels-1:0][SampleW-1:0] first;
		logic [Pixels-1:0][SampleW-1:0] green;
		logic [Pixels-1:0][SampleW-1:0] third;
	} ycq_pix_t;

endpackage

// File: hdl/ycq_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycq_mul
// First stage: offsets removed and all coefficient products registered.
// ----------------------------------------------------------------------------
module ycq_mul
	import ycq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ycq_quad_t in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output ycq_prod_t out_data
);

	logic                 valid_s1;
	ycq_prod_t            prod_s1;
	ycq_prod_t            prod_d;
	logic signed [ProdW-1:0] cb_x;
	logic signed [ProdW-1:0] cr_x;
	logic signed [ProdW-1:0] yv_x [Pixels];
	logic signed [ProdW-1:0] y_full [Pixels];
	logic signed [ProdW-1:0] red_full;
	logic signed [ProdW-1:0] blue_full;
	logic signed [ProdW-1:0] gcr_full;
	logic signed [ProdW-1:0] gcb_full;

	assign in_ready = !valid_s1 || out_ready;

	always_comb begin
		cb_x = $signed({10'd0, in_data.chroma_blue}) - ChromaOfs;
		cr_x = $signed({10'd0, in_data.chroma_red}) - ChromaOfs;
		red_full  = CoefCrRed * cr_x + RoundHalf;
		blue_full = CoefCbBlu * cb_x + RoundHalf;
		gcr_full  = CoefCrGrn * cr_x + RoundHalf;
		gcb_full  = CoefCbGrn * cb_x + RoundHalf;
		for (int i = 0; i < Pixels; i++) begin
			yv_x[i]   = $signed({10'd0, in_data.luma[i]}) - LumaOfs;
			y_full[i] = CoefY * yv_x[i];
			prod_d.y_prod[i] = y_full[i];
		end
		prod_d.red_prod    = red_full[16:0];
		prod_d.blue_prod   = blue_full[17:0];
		prod_d.grn_cr_prod = gcr_full[15:0];
		prod_d.grn_cb_prod = gcb_full[14:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			prod_s1 <= prod_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = prod_s1;

endmodule

// File: hdl/ycq_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycq_sum
// Second stage: floor shift of each product and the channel sums.
// ----------------------------------------------------------------------------
module ycq_sum
	import ycq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  ycq_prod_t in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output ycq_sum_t  out_data
);

	logic                    valid_s2;
	ycq_sum_t                sum_s2;
	ycq_sum_t                sum_d;
	logic signed [SumW-1:0]  yterm;
	logic signed [SumW-1:0]  red_add;
	logic signed [SumW-1:0]  blue_add;
	logic signed [SumW-1:0]  green_sub;

	assign in_ready = !valid_s2 || out_ready;

	// dropping the low byte of a two's complement value is a floor shift
	always_comb begin
		red_add   = $signed({{2{in_data.red_prod[16]}}, in_data.red_prod[16:8]});
		blue_add  = $signed({in_data.blue_prod[17], in_data.blue_prod[17:8]});
		green_sub = $signed({{3{in_data.grn_cr_prod[15]}}, in_data.grn_cr_prod[15:8]})
			+ $signed({{4{in_data.grn_cb_prod[14]}}, in_data.grn_cb_prod[14:8]});
		for (int i = 0; i < Pixels; i++) begin
			yterm = $signed({in_data.y_prod[i][17], in_data.y_prod[i][17:8]});
			sum_d.red[i]   = yterm + red_add;
			sum_d.green[i] = yterm - green_sub;
			sum_d.blue[i]  = yterm + blue_add;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sum_s2 <= sum_d;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = sum_s2;

endmodule

// File: hdl/ycq_clamp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycq_clamp
// Third stage: clamp to 0..255 and red/blue order, output register.
// ----------------------------------------------------------------------------
module ycq_clamp
	import ycq_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     swap_rb,
	input  logic     in_valid,
	output logic     in_ready,
	input  ycq_sum_t in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output ycq_pix_t out_data
);

	logic     valid_s3;
	ycq_pix_t pix_s3;
	ycq_pix_t pix_d;
	logic [SampleW-1:0] red_c;
	logic [SampleW-1:0] blue_c;

	function automatic logic [SampleW-1:0] clamp_u8(input logic [SumW-1:0] v);
		logic [SampleW-1:0] r;
		if (v[SumW-1]) begin
			r = '0;
		end else if (v[SumW-2:SampleW] != '0) begin
			r = '1;
		end else begin
			r = v[SampleW-1:0];
		end
		return r;
	endfunction

	assign in_ready = !valid_s3 || out_ready;

	always_comb begin
		for (int i = 0; i < Pixels; i++) begin
			red_c  = clamp_u8(in_data.red[i]);
			blue_c = clamp_u8(in_data.blue[i]);
			pix_d.first[i] = swap_rb ? blue_c : red_c;
			pix_d.green[i] = clamp_u8(in_data.green[i]);
			pix_d.third[i] = swap_rb ? red_c : blue_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pix_s3 <= pix_d;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = pix_s3;

endmodule

// File: hdl/ycbcr420_quad_to_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycbcr420_quad_to_rgb
// One 4:2:0 quad (four luma, shared Cb/Cr) to four 8-bit RGB pixels, bt.601.
// ----------------------------------------------------------------------------
//  channel  | direction | payload
//  s_*      | in        | quad: 4 luma + Cb + Cr, 48 bits
//  m_*      | out       | 4 pixels x 3 channels, 96 bits
//  cfg_wr_* | in        | swap_red_blue, 1 bit
//
// one item per clock sustained unless m_tready stalls; each item is registered
// through the product, sum and clamp register stages.
// reset clears the stage valid bits and swap_red_blue; no clearing pass.
// a stall at m_tready holds each full stage with no empty stage after it; empty
// stages still take items, so s_tready stays high while any stage is empty.
// ----------------------------------------------------------------------------
module ycbcr420_quad_to_rgb
	import ycq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
	// chroma_blue, chroma_red
	input  logic [47:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tl_first, tl_green, tl_third, tr_first, tr_green, tr_third,
	// bl_first, bl_green, bl_third, br_first, br_green, br_third
	output logic [95:0] m_tdata
);

	logic      swap_q;
	ycq_quad_t quad;
	logic      mul_valid;
	logic      mul_ready;
	ycq_prod_t mul_data;
	logic      sum_valid;
	logic      sum_ready;
	ycq_sum_t  sum_data;
	ycq_pix_t  pix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q <= 1'b0;
		end else if (cfg_wr_en) begin
			swap_q <= cfg_wr_data;
		end
	end

	always_comb begin
		for (int i = 0; i < Pixels; i++) begin
			quad.luma[i] = s_tdata[i*SampleW +: SampleW];
		end
		quad.chroma_blue = s_tdata[39:32];
		quad.chroma_red  = s_tdata[47:40];
		for (int i = 0; i < Pixels; i++) begin
			m_tdata[i*24 +: 8]      = pix.first[i];
			m_tdata[i*24 + 8 +: 8]  = pix.green[i];
			m_tdata[i*24 + 16 +: 8] = pix.third[i];
		end
	end

	ycq_mul u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (quad),
		.out_valid (mul_valid),
		.out_ready (mul_ready),
		.out_data  (mul_data)
	);

	ycq_sum u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mul_valid),
		.in_ready  (mul_ready),
		.in_data   (mul_data),
		.out_valid (sum_valid),
		.out_ready (sum_ready),
		.out_data  (sum_data)
	);

	ycq_clamp u_clamp (
		.clk       (clk),
		.arst_n    (arst_n),
		.swap_rb   (swap_q),
		.in_valid  (sum_valid),
		.in_ready  (sum_ready),
		.in_data   (sum_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (pix)
	);

`ifndef NO_ASSERTIONS
	// an empty output stage lets the whole pipe advance
	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output stage");

	// with no back pressure an item moves through the product, sum and clamp registers to the output
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) ##1 m_tready ##1 m_tready |=> m_tvalid)
		else $error("item lost in pipeline");

	// output can only fill from a full sum stage
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(sum_valid))
		else $error("output valid without source item");

	// a full sum stage never sits behind an idle output stage
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		(sum_valid && !m_tvalid) |=> m_tvalid)
		else $error("sum stage did not advance");
`endif

endmodule

// File: dv/ycq_pixel_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycq_pixel_checker
// Watches the quad and pixel streams of the 4:2:0 quad to RGB converter,
// predicts the four pixels of every accepted quad with the current red/blue
// order and compares each channel of every accepted result in order.
// ----------------------------------------------------------------------------
module ycq_pixel_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [95:0] m_tdata,
	output int          errors,
	output int          pending,
	output int          checked
);

	logic        swap_seen;
	logic [95:0] expected_pixels [$];

	function automatic logic [7:0] sat8(int v);
		if (v < 0)
			return 8'd0;
		if (v > 255)
			return 8'hff;
		return v[7:0];
	endfunction

	// bt.601 limited range, coefficients scaled by 256, shifts floor
	function automatic logic [95:0] quad_to_pixels(logic [47:0] quad, logic swap);
		int         cb, cr, red_add, blue_add, green_sub, yterm;
		logic [7:0] red, green, blue;
		logic [95:0] px;
		cb        = int'(quad[39:32]) - 128;
		cr        = int'(quad[47:40]) - 128;
		red_add   = (409 * cr + 128) >>> 8;
		blue_add  = (516 * cb + 128) >>> 8;
		green_sub = ((208 * cr + 128) >>> 8) + ((100 * cb + 128) >>> 8);
		for (int p = 0; p < 4; p++) begin
			yterm = (298 * (int'(quad[p*8 +: 8]) - 16)) >>> 8;
			red   = sat8(yterm + red_add);
			green = sat8(yterm - green_sub);
			blue  = sat8(yterm + blue_add);
			px[p*24 +: 8]      = swap ? blue : red;
			px[p*24 + 8 +: 8]  = green;
			px[p*24 + 16 +: 8] = swap ? red : blue;
		end
		return px;
	endfunction

	initial errors = 0;

	always @(posedge clk or negedge arst_n) begin
		logic [95:0] want;
		if (!arst_n) begin
			swap_seen <= 1'b0;
			pending   <= 0;
			checked   <= 0;
		end else begin
			// results first: an item taken at this edge cannot leave at it
			if (m_tvalid && m_tready) begin
				if (expected_pixels.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected pixel item %h with no quad outstanding", m_tdata);
				end else begin
					want = expected_pixels.pop_front();
					for (int f = 0; f < 12; f++) begin
						if (m_tdata[f*8 +: 8] !== want[f*8 +: 8]) begin
							errors++;
							if (errors <= 10)
								$display("pixel item %0d field %0d (pixel %0d chan %0d): expected %h got %h",
									checked, f, f / 3, f % 3, want[f*8 +: 8], m_tdata[f*8 +: 8]);
						end
					end
				end
				checked <= checked + 1;
			end
			if (s_tvalid && s_tready)
				expected_pixels.push_back(quad_to_pixels(s_tdata, swap_seen));
			if (cfg_wr_en)
				swap_seen <= cfg_wr_data;
			pending <= expected_pixels.size();
		end
	end

endmodule

// File: dv/ycbcr420_quad_to_rgb_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ycbcr420_quad_to_rgb_tb
// Drives corner and random 4:2:0 quads into the converter under bursty input
// and a stalling output, switches the red/blue order between drained phases
// and leaves the per-channel checking to ycq_pixel_checker.
// ----------------------------------------------------------------------------
module ycbcr420_quad_to_rgb_tb;

	localparam int LongHold = 200;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic        cfg_wr_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // luma tl, tr, bl, br, chroma blue, chroma red
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;   // tl first/green/third, tr, bl, br likewise
	int          errors, pending, checked;
	int          quads_sent = 0;
	int          holds_done = 0;
	bit          hold_req = 1'b0;

	always #5 clk = ~clk;

	ycbcr420_quad_to_rgb dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

	ycq_pixel_checker pixel_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.errors     (errors),
		.pending    (pending),
		.checked    (checked)
	);

	function automatic logic [47:0] pack_quad(logic [7:0] tl, logic [7:0] tr, logic [7:0] bl,
		logic [7:0] br, logic [7:0] cb, logic [7:0] cr);
		return {cr, cb, br, bl, tr, tl};
	endfunction

	function automatic logic [7:0] pick_sample();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'hff;
			2: return $urandom_range(0, 1) ? 8'd16 : 8'd235;
			3: return 8'd128;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [47:0] random_quad();
		return pack_quad(pick_sample(), pick_sample(), pick_sample(),
			pick_sample(), pick_sample(), pick_sample());
	endfunction

	// black, white, full-scale and clamping chroma, mixed luma per pixel
	function automatic logic [47:0] corner_quad(int k);
		case (k)
			0:  return pack_quad(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
			1:  return pack_quad(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
			2:  return pack_quad(8'd16, 8'd16, 8'd16, 8'd16, 8'd128, 8'd128);
			3:  return pack_quad(8'd235, 8'd235, 8'd235, 8'd235, 8'd128, 8'd128);
			4:  return pack_quad(8'd0, 8'hff, 8'd16, 8'd235, 8'd0, 8'd0);
			5:  return pack_quad(8'd0, 8'hff, 8'd16, 8'd235, 8'hff, 8'hff);
			6:  return pack_quad(8'd0, 8'hff, 8'd16, 8'd235, 8'd0, 8'hff);
			7:  return pack_quad(8'd0, 8'hff, 8'd16, 8'd235, 8'hff, 8'd0);
			8:  return pack_quad(8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa);
			9:  return pack_quad(8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55);
			10: return pack_quad(8'd128, 8'd17, 8'd15, 8'd240, 8'd127, 8'd129);
			default: return pack_quad(8'd81, 8'd145, 8'd41, 8'd210, 8'd90, 8'd240);
		endcase
	endfunction

	// returns at the edge that takes the quad, with s_tvalid still high
	task automatic push_quad(logic [47:0] quad);
		s_tvalid <= 1'b1;
		s_tdata  <= quad;
		do
			@(posedge clk);
		while (!s_tready);
		quads_sent++;
	endtask

	task automatic sender_gap(int cycles);
		s_tvalid <= 1'b0;
		s_tdata  <= 48'({$urandom, $urandom});
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain_pixels();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	task automatic write_swap(logic value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	task automatic send_random(int count);
		int burst;
		while (count > 0) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && count > 0) begin
				push_quad(random_quad());
				burst--;
				count--;
			end
			if ($urandom_range(0, 3) != 0)
				sender_gap($urandom_range(1, 8));
		end
	endtask

	// receiver: segments of always ready, mostly ready, periodic and mostly stalled
	initial begin
		int mode, span, tick;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(4, 60);
			for (tick = 0; tick < span; tick++) begin
				if (hold_req) begin
					m_tready <= 1'b0;
					repeat (LongHold) @(posedge clk);
					hold_req = 1'b0;
					holds_done++;
				end
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= ($urandom_range(0, 9) < 7);
					2: m_tready <= (tick % 3 != 2);
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin
		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= 1'b0;
		s_tvalid    <= 1'b0;
		s_tdata     <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// corner quads with the reset channel order, then swapped
		for (int k = 0; k < 12; k++)
			push_quad(corner_quad(k));
		drain_pixels();
		write_swap(1'b1);
		for (int k = 0; k < 12; k++)
			push_quad(corner_quad(k));
		drain_pixels();

		for (int phase = 0; phase < 6; phase++) begin
			write_swap(phase % 2 == 0 ? 1'b0 : 1'b1);
			if (phase == 2) begin
				// output held off while quads keep coming, so the pipe backs up
				hold_req = 1'b1;
				for (int k = 0; k < 60; k++)
					push_quad(random_quad());
			end
			send_random(140);
			drain_pixels();
		end

		repeat (8) @(posedge clk);
		$display("covered %0d quads incl. 24 corner quads, %0d pixel items checked", quads_sent,
			checked);
		$display("both red/blue orders, bursty input, stalled output, %0d long output hold(s)",
			holds_done);
		if (errors == 0 && pending == 0) begin
			$display("ycbcr420_quad_to_rgb regression: pass");
		end else begin
			$display("ycbcr420_quad_to_rgb regression: fail");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d pixel items outstanding", pending);
		$display("ycbcr420_quad_to_rgb regression: fail");
		$finish;
	end

endmodule
